// ===== hw/rtl/lir_pkg.sv =====
// Shared types and constants for the linear interpolation resampler.
package lir_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_BITS  = 32;
  localparam int RATE_W      = 18;
  localparam int OFFSET_W    = 20;
  localparam int MAX_RESULTS = 50;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  // 2*(count+1) operand of the tail test, split in two halves for the multiplier
  localparam int WIDE_A_W  = COUNT_BITS + 2;
  localparam int HALF_W    = (WIDE_A_W + 1) / 2;
  localparam int MUL_A_W   = (HALF_W > SAMPLE_BITS) ? HALF_W : SAMPLE_BITS;
  localparam int MUL_P_W   = MUL_A_W + RATE_W;
  localparam int WIDE_W    = WIDE_A_W + RATE_W;

  // divider: numerator 2*mag*rem + dst, divisor 2*dst
  localparam int NUM_W     = MUL_P_W + 1;
  localparam int DIV_W     = RATE_W + 1;
  localparam int DCNT_W    = $clog2(SAMPLE_BITS + 1);

  localparam int CFG_IDX_W = 1;
  localparam logic [RATE_W-1:0] SRC_RATE_RST = RATE_W'(48000);
  localparam logic [RATE_W-1:0] DST_RATE_RST = RATE_W'(16000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_RATE,
    REG_TARGET_RATE
  } lir_reg_e;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          end_of_stream;
  } lir_in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          final_out;
  } lir_res_t;

  typedef struct packed {
    logic                   push;
    logic                   flush;
    logic                   last;
    logic [SAMPLE_BITS-1:0] data;
  } lir_out_cmd_t;

endpackage

// ===== hw/rtl/lir_div.sv =====
// Serial restoring divider, one quotient bit per cycle.
module lir_div import lir_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [NUM_W-1:0]       num_i,
  input  logic [DIV_W-1:0]       den_i,
  output logic                   busy_o,
  output logic [SAMPLE_BITS-1:0] quo_o
);

  logic [DCNT_W-1:0]      cnt_q;
  logic [DIV_W-1:0]       r_q;
  logic [DIV_W-1:0]       den_q;
  logic [SAMPLE_BITS-1:0] sh_q;
  logic [DIV_W:0]         r2;
  logic [DIV_W:0]         diff;
  logic                   ge;
  logic [DIV_W-1:0]       r_d;

  assign r2   = {r_q, sh_q[SAMPLE_BITS-1]};
  assign diff = r2 - {1'b0, den_q};
  assign ge   = r2 >= {1'b0, den_q};
  assign r_d  = ge ? diff[DIV_W-1:0] : r2[DIV_W-1:0];

  assign busy_o = cnt_q != '0;
  assign quo_o  = sh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= DCNT_W'(SAMPLE_BITS);
    end else if (busy_o) begin
      cnt_q <= cnt_q - DCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      r_q   <= DIV_W'(num_i[NUM_W-1:SAMPLE_BITS]);
      sh_q  <= num_i[SAMPLE_BITS-1:0];
      den_q <= den_i;
    end else if (busy_o) begin
      r_q  <= r_d;
      sh_q <= {sh_q[SAMPLE_BITS-2:0], ge};
    end
  end

endmodule

// ===== hw/rtl/lir_out.sv =====
// One-word hold stage and output register; the held word learns its final mark late.
module lir_out import lir_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  lir_out_cmd_t cmd_i,
  output logic         ok_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output lir_res_t     out_data_o
);

  logic                   hold_valid_q;
  logic [SAMPLE_BITS-1:0] hold_q;
  logic                   out_valid_q;
  lir_res_t               out_q;
  logic                   load_hold;
  logic                   load_out;

  assign ok_o      = !hold_valid_q || !out_valid_q || out_ready_i;
  assign load_hold = cmd_i.push && ok_o;
  assign load_out  = hold_valid_q && ok_o && (cmd_i.push || cmd_i.flush);

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (load_hold) begin
        hold_valid_q <= 1'b1;
      end else if (load_out) begin
        hold_valid_q <= 1'b0;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_hold) begin
      hold_q <= cmd_i.data;
    end
    if (load_out) begin
      out_q.sample_out <= hold_q;
      out_q.final_out  <= cmd_i.flush && !cmd_i.push && cmd_i.last;
    end
  end

endmodule

// ===== hw/rtl/linear_interpolation_resampler.sv =====
// Streaming linear interpolation sample-rate converter, top level.
// The block takes one word at a time and is not ready until it is done with it. Each
// interpolated output is computed by the 16-step serial divider; outputs past the limit are
// dropped and stepped over. On the last word the tail sets up the tail test and emits tail
// outputs, with a closing test, all through one shared 17x18 multiplier. Equal or zero rates
// pass a word straight through. At most 50 outputs leave per input word; a stalled output side
// keeps the block busy until it takes the word.
module linear_interpolation_resampler import lir_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [RATE_W-1:0]    cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  lir_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output lir_res_t             out_data_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_LOOP, S_MUL, S_DIVGO, S_DIV, S_EMIT, S_UPD,
    S_RHS_LO, S_RHS_HI, S_TCHK, S_LHS_LO, S_LHS_HI, S_TCMP, S_FLUSH
  } state_e;

  state_e                 state_q;
  logic [RATE_W-1:0]      src_q;
  logic [RATE_W-1:0]      dst_q;
  logic [SAMPLE_BITS-1:0] s_q;
  logic                   eos_q;
  logic                   tail_q;
  logic [SAMPLE_BITS-1:0] prev_q;
  logic                   have_q;
  logic [OFFSET_W-1:0]    noff_q;
  logic [OFFSET_W-1:0]    o_q;
  logic [COUNT_BITS-1:0]  in_cnt_q;
  logic [COUNT_BITS-1:0]  out_cnt_q;
  logic [RES_CNT_W-1:0]   n_q;
  logic [MUL_P_W-1:0]     prod_q;
  logic [WIDE_W-1:0]      lhs_q;
  logic [WIDE_W-1:0]      rhs_q;

  logic                   accept;
  logic                   bypass;
  logic [OFFSET_W-1:0]    src_w;
  logic [OFFSET_W-1:0]    dst_w;
  logic [SAMPLE_BITS:0]   diff;
  logic                   neg;
  logic [SAMPLE_BITS:0]   mag_w;
  logic [SAMPLE_BITS:0]   interp_w;
  logic [SAMPLE_BITS-1:0] emit_val;
  logic [WIDE_A_W-1:0]    two_n;
  logic [COUNT_BITS:0]    i1;
  logic [WIDE_A_W-1:0]    two_i1;
  logic [MUL_A_W-1:0]     mul_a;
  logic [RATE_W-1:0]      mul_b;
  logic [MUL_P_W-1:0]     mul_p;
  logic                   div_start;
  logic                   div_busy;
  logic [NUM_W-1:0]       div_num;
  logic [SAMPLE_BITS-1:0] quo;
  logic                   out_ok;
  lir_out_cmd_t           out_cmd;

  assign in_ready_o = state_q == S_IDLE;
  assign accept     = in_valid_i && in_ready_o;
  assign bypass     = (src_q == dst_q) || (src_q == '0) || (dst_q == '0);
  assign src_w      = OFFSET_W'(src_q);
  assign dst_w      = OFFSET_W'(dst_q);

  // interpolation: prev + sign(d) * round(|d| * rem / dst)
  assign diff     = {s_q[SAMPLE_BITS-1], s_q} - {prev_q[SAMPLE_BITS-1], prev_q};
  assign neg      = diff[SAMPLE_BITS];
  assign mag_w    = neg ? (~diff + (SAMPLE_BITS+1)'(1)) : diff;
  assign interp_w = neg ? ({prev_q[SAMPLE_BITS-1], prev_q} - {1'b0, quo})
                        : ({prev_q[SAMPLE_BITS-1], prev_q} + {1'b0, quo});
  assign emit_val = tail_q ? s_q : interp_w[SAMPLE_BITS-1:0];

  // tail test operands: 2*N and 2*(i+1)
  assign two_n  = {1'b0, in_cnt_q, 1'b0};
  assign i1     = {1'b0, out_cnt_q} + (COUNT_BITS+1)'(1);
  assign two_i1 = {i1, 1'b0};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_MUL: begin
        mul_a = MUL_A_W'(mag_w[SAMPLE_BITS-1:0]);
        mul_b = o_q[RATE_W-1:0];
      end
      S_RHS_LO: begin
        mul_a = MUL_A_W'(two_n[HALF_W-1:0]);
        mul_b = dst_q;
      end
      S_RHS_HI: begin
        mul_a = MUL_A_W'(two_n[WIDE_A_W-1:HALF_W]);
        mul_b = dst_q;
      end
      S_LHS_LO: begin
        mul_a = MUL_A_W'(two_i1[HALF_W-1:0]);
        mul_b = src_q;
      end
      S_LHS_HI: begin
        mul_a = MUL_A_W'(two_i1[WIDE_A_W-1:HALF_W]);
        mul_b = src_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

  assign div_start = state_q == S_DIVGO;
  assign div_num   = {prod_q, 1'b0} + NUM_W'(dst_q);

  lir_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   ({dst_q, 1'b0}),
    .busy_o  (div_busy),
    .quo_o   (quo)
  );

  always_comb begin
    out_cmd.push  = (accept && bypass) || (state_q == S_EMIT);
    out_cmd.flush = state_q == S_FLUSH;
    out_cmd.last  = eos_q;
    out_cmd.data  = (state_q == S_IDLE) ? in_data_i.sample_in : emit_val;
  end

  lir_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (out_cmd),
    .ok_o        (out_ok),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      src_q     <= SRC_RATE_RST;
      dst_q     <= DST_RATE_RST;
      s_q       <= '0;
      eos_q     <= 1'b0;
      tail_q    <= 1'b0;
      prev_q    <= '0;
      have_q    <= 1'b0;
      noff_q    <= '0;
      o_q       <= '0;
      in_cnt_q  <= '0;
      out_cnt_q <= '0;
      n_q       <= '0;
      prod_q    <= '0;
      lhs_q     <= '0;
      rhs_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (lir_reg_e'(cfg_idx_i))
          REG_SOURCE_RATE: src_q <= cfg_data_i;
          REG_TARGET_RATE: dst_q <= cfg_data_i;
        endcase
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            s_q    <= in_data_i.sample_in;
            eos_q  <= in_data_i.end_of_stream;
            tail_q <= 1'b0;
            n_q    <= '0;
            o_q    <= noff_q;
            priority if (bypass) begin
              state_q <= S_FLUSH;
            end else if (have_q) begin
              state_q <= S_LOOP;
            end else begin
              state_q <= S_UPD;
            end
          end
        end
        S_LOOP: begin
          if (o_q < dst_w) begin
            if (n_q < RES_CNT_W'(MAX_RESULTS)) begin
              state_q <= S_MUL;
            end else begin
              // result budget spent: step past the dropped outputs
              o_q       <= o_q + src_w;
              out_cnt_q <= out_cnt_q + COUNT_BITS'(1);
            end
          end else begin
            noff_q  <= o_q - dst_w;
            state_q <= S_UPD;
          end
        end
        S_MUL: begin
          prod_q  <= mul_p;
          state_q <= S_DIVGO;
        end
        S_DIVGO: begin
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (!div_busy) begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_ok) begin
            n_q       <= n_q + RES_CNT_W'(1);
            out_cnt_q <= out_cnt_q + COUNT_BITS'(1);
            if (tail_q) begin
              state_q <= S_TCHK;
            end else begin
              o_q     <= o_q + src_w;
              state_q <= S_LOOP;
            end
          end
        end
        S_UPD: begin
          prev_q   <= s_q;
          have_q   <= 1'b1;
          in_cnt_q <= in_cnt_q + COUNT_BITS'(1);
          if (eos_q) begin
            tail_q  <= 1'b1;
            state_q <= S_RHS_LO;
          end else begin
            state_q <= S_FLUSH;
          end
        end
        S_RHS_LO: begin
          rhs_q   <= WIDE_W'(mul_p) + WIDE_W'(src_q);
          state_q <= S_RHS_HI;
        end
        S_RHS_HI: begin
          rhs_q   <= rhs_q + (WIDE_W'(mul_p) << HALF_W);
          state_q <= S_TCHK;
        end
        S_TCHK: begin
          priority if (n_q >= RES_CNT_W'(MAX_RESULTS)) begin
            state_q <= S_FLUSH;
          end else if (out_cnt_q == '0) begin
            state_q <= S_EMIT;
          end else begin
            state_q <= S_LHS_LO;
          end
        end
        S_LHS_LO: begin
          lhs_q   <= WIDE_W'(mul_p);
          state_q <= S_LHS_HI;
        end
        S_LHS_HI: begin
          lhs_q   <= lhs_q + (WIDE_W'(mul_p) << HALF_W);
          state_q <= S_TCMP;
        end
        S_TCMP: begin
          state_q <= (lhs_q <= rhs_q) ? S_EMIT : S_FLUSH;
        end
        S_FLUSH: begin
          if (out_ok) begin
            if (eos_q) begin
              prev_q    <= '0;
              have_q    <= 1'b0;
              noff_q    <= '0;
              in_cnt_q  <= '0;
              out_cnt_q <= '0;
            end
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule
